[design/efd_pkg.sv]
`default_nettype none
package efd_pkg;

  localparam int ByteW = 8;
  localparam int NibbleW = 4;
  localparam int CfgIndexW = 1;

  // register indexes on the configuration channel
  localparam logic [CfgIndexW-1:0] CFG_ESCAPE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_TRUNCATION = 1'b1;

  localparam logic [ByteW-1:0] ESCAPE_RESET = 8'h2C;
  localparam logic [ByteW-1:0] TRUNCATION_RESET = 8'h2D;
  localparam logic [ByteW-1:0] SLASH_BYTE = 8'h2F;
  localparam logic [ByteW-1:0] DOT_BYTE = 8'h2E;

  typedef enum logic [4:0] {
    MODE_START = 5'b00001,
    MODE_ESC   = 5'b00010,
    MODE_DIGIT = 5'b00100,
    MODE_TRUNC = 5'b01000,
    MODE_DOT   = 5'b10000
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [NibbleW-1:0] high_nibble;
    logic               failed;
  } parse_state_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_valid;
    logic             name_done;
    logic             decode_ok;
  } result_t;

  typedef struct packed {
    logic               ok;
    logic [NibbleW-1:0] val;
  } hex_t;

  localparam parse_state_t STATE_RESET = '{mode: MODE_START, high_nibble: '0, failed: 1'b0};

  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    h.ok = 1'b0;
    h.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok = 1'b1;
      h.val = NibbleW'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok = 1'b1;
      h.val = NibbleW'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok = 1'b1;
      h.val = NibbleW'(c - 8'h57);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

[design/efd_step.sv]
`default_nettype none
module efd_step (
  input  wire logic [efd_pkg::ByteW-1:0] in_byte,
  input  wire logic                      in_last,
  input  wire logic [efd_pkg::ByteW-1:0] escape_byte,
  input  wire logic [efd_pkg::ByteW-1:0] truncation_byte,
  input  efd_pkg::parse_state_t          state,
  output efd_pkg::parse_state_t          state_next,
  output efd_pkg::result_t               result
);
  import efd_pkg::*;

  hex_t         hex;
  parse_state_t upd;

  always_comb begin
    hex = hex_decode(in_byte);
    upd = state;
    result.out_byte = '0;
    result.out_valid = 1'b0;

    if (!state.failed) begin
      unique case (state.mode)
        MODE_ESC: begin
          if (hex.ok) begin
            upd.high_nibble = hex.val;
            upd.mode = MODE_DIGIT;
          end else if (in_byte == truncation_byte) begin
            upd.mode = MODE_TRUNC;
          end else if (in_byte == DOT_BYTE) begin
            result.out_byte = DOT_BYTE;
            result.out_valid = 1'b1;
            upd.mode = MODE_DOT;
          end else if (in_byte == SLASH_BYTE) begin
            result.out_byte = SLASH_BYTE;
            result.out_valid = 1'b1;
            upd.mode = MODE_START;
          end else begin
            upd.failed = 1'b1;
          end
        end
        MODE_DIGIT: begin
          if (hex.ok) begin
            result.out_byte = {state.high_nibble, hex.val};
            result.out_valid = 1'b1;
            upd.mode = MODE_START;
          end else begin
            upd.failed = 1'b1;
          end
        end
        MODE_TRUNC: begin
          if (in_byte == SLASH_BYTE) begin
            upd.mode = MODE_START;
          end else begin
            upd.failed = 1'b1;
          end
        end
        MODE_DOT: begin
          result.out_byte = in_byte;
          result.out_valid = 1'b1;
          upd.mode = MODE_START;
        end
        default: begin
          // start mode, and any code that cannot arise
          if (in_byte == escape_byte) begin
            upd.mode = MODE_ESC;
          end else begin
            result.out_byte = in_byte;
            result.out_valid = 1'b1;
          end
        end
      endcase
    end

    result.name_done = in_last;
    result.decode_ok = in_last && !upd.failed && (upd.mode == MODE_ESC);
    state_next = in_last ? STATE_RESET : upd;
  end

endmodule
`default_nettype wire

[design/escaped_filename_decoder.sv]
`default_nettype none
// Escaped filename decoder: takes an encoded filename one byte per transaction on the
// slave stream (tlast on the final byte) and gives exactly one result transaction per
// input byte on the master stream. tuser[0] says whether tdata holds a decoded byte;
// on the result for the last byte tlast is high and tuser[1] reports whether the whole
// name decoded legally (it must end right after an escape byte and contain no malformed
// sequence). After the last byte the parser returns to its start state. The block sustains
// one byte per cycle while the master stream takes results: a byte sits in an input
// register, the parse step is decoded into the result register, and the parser state is
// updated as the byte moves on. The user must write the escape and truncation bytes on
// the configuration channel only while the block is idle; the block does not enforce it.
module escaped_filename_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // slave stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [efd_pkg::ByteW-1:0]          s_axis_tdata,   // [7:0] in_byte
  input  wire logic                               s_axis_tlast,   // in_last
  // master stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [efd_pkg::ByteW-1:0]               m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]                              m_axis_tuser,   // [0] out_valid, [1] decode_ok
  output logic                                    m_axis_tlast,   // name_done
  // configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [efd_pkg::CfgIndexW-1:0]      cfg_index,
  input  wire logic [efd_pkg::ByteW-1:0]          cfg_data
);
  import efd_pkg::*;

  // configuration registers
  logic [ByteW-1:0] escape_byte;
  logic [ByteW-1:0] truncation_byte;

  // input register
  logic             in_full;
  logic [ByteW-1:0] in_byte;
  logic             in_last;

  // parser state and result register
  parse_state_t     state;
  parse_state_t     state_next;
  result_t          result_next;
  result_t          result;
  logic             out_full;

  // a byte moves on when the result register is empty or is being drained
  logic             advance;

  assign advance = in_full && (!out_full || m_axis_tready);
  assign s_axis_tready = !in_full || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_byte <= ESCAPE_RESET;
      truncation_byte <= TRUNCATION_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ESCAPE:     escape_byte <= cfg_data;
        CFG_TRUNCATION: truncation_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  efd_step u_step (
    .in_byte         (in_byte),
    .in_last         (in_last),
    .escape_byte     (escape_byte),
    .truncation_byte (truncation_byte),
    .state           (state),
    .state_next      (state_next),
    .result          (result_next)
  );

  // parser state follows each byte as it is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = result.out_byte;
  assign m_axis_tuser = {result.decode_ok, result.out_valid};
  assign m_axis_tlast = result.name_done;

endmodule
`default_nettype wire
